// ===== rtl/core/frm_pkg.sv =====
// Shared types and constants for the frame rotate/mirror/crop unit.
package frm_pkg;

	localparam int MAX_DIM     = 64;
	localparam int STORE_DEPTH = 4096;

	localparam int DIM_W   = 7;                          // width of a dimension register
	localparam int POS_W   = $clog2(MAX_DIM);            // output row / column
	localparam int ADDR_W  = $clog2(STORE_DEPTH);        // pixel store address
	localparam int FRAME_W = 2 * DIM_W;                  // width * height
	localparam int CIDX_W  = 3;                          // register index

	// Transform modes
	localparam logic [2:0] MODE_ROT_CCW  = 3'd0;
	localparam logic [2:0] MODE_ROT_CW   = 3'd1;
	localparam logic [2:0] MODE_MIRROR_H = 3'd2;
	localparam logic [2:0] MODE_MIRROR_V = 3'd3;
	localparam logic [2:0] MODE_CROP     = 3'd4;

	// Register indexes
	localparam logic [CIDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [CIDX_W-1:0] REG_WIDTH  = 3'd1;
	localparam logic [CIDX_W-1:0] REG_HEIGHT = 3'd2;
	localparam logic [CIDX_W-1:0] REG_CROP_W = 3'd3;
	localparam logic [CIDX_W-1:0] REG_CROP_H = 3'd4;

	// Opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       last;
	} out_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	// Mapping result handed from the address generator to the top level
	typedef struct packed {
		logic [ADDR_W-1:0] rd_addr;
		logic              black;
		logic              last;
		logic [POS_W-1:0]  nxt_row;
		logic [POS_W-1:0]  nxt_col;
		logic              wr_wrap;
	} map_t;

endpackage

// ===== rtl/core/frm_store.sv =====
// Pixel store: one write port, one registered read port.
module frm_store (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [frm_pkg::ADDR_W-1:0]  wr_addr,
	input  frm_pkg::pix_t               wr_data,
	input  logic                        rd_en,
	input  logic [frm_pkg::ADDR_W-1:0]  rd_addr,
	output frm_pkg::pix_t               rd_data
);

	frm_pkg::pix_t mem [frm_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/frm_map.sv =====
// Output position to store address mapping, frame wrap and write wrap.
module frm_map (
	input  logic [2:0]                  mode,
	input  logic [frm_pkg::DIM_W-1:0]   width,
	input  logic [frm_pkg::DIM_W-1:0]   height,
	input  logic [frm_pkg::DIM_W-1:0]   crop_w,
	input  logic [frm_pkg::DIM_W-1:0]   crop_h,
	input  logic [frm_pkg::POS_W-1:0]   row,
	input  logic [frm_pkg::POS_W-1:0]   col,
	input  logic [frm_pkg::ADDR_W-1:0]  write_idx,
	output frm_pkg::map_t               map
);

	localparam int DW = frm_pkg::DIM_W;
	localparam int FW = frm_pkg::FRAME_W;

	function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
		logic [DW-1:0] res;
		res = v;
		if (v == '0) begin
			res = DW'(1);
		end else if (v > DW'(frm_pkg::MAX_DIM)) begin
			res = DW'(frm_pkg::MAX_DIM);
		end
		return res;
	endfunction

	logic [DW-1:0] w, h, ow, oh;
	logic [DW-1:0] r, c, src_r, src_c;
	logic [FW-1:0] prod, sum, frame;
	logic          col_end, row_end;

	always_comb begin
		w = clamp_dim(width);
		h = clamp_dim(height);
		case (mode)
			frm_pkg::MODE_ROT_CCW, frm_pkg::MODE_ROT_CW: begin
				ow = h;
				oh = w;
			end
			frm_pkg::MODE_CROP: begin
				ow = clamp_dim(crop_w);
				oh = clamp_dim(crop_h);
			end
			default: begin
				ow = w;
				oh = h;
			end
		endcase

		// restart at the origin when the position fell outside the frame
		r = DW'(row);
		c = DW'(col);
		if (r >= oh || c >= ow) begin
			r = '0;
			c = '0;
		end

		case (mode)
			frm_pkg::MODE_ROT_CCW: begin
				src_r = c;
				src_c = w - DW'(1) - r;
			end
			frm_pkg::MODE_ROT_CW: begin
				src_r = h - DW'(1) - c;
				src_c = r;
			end
			frm_pkg::MODE_MIRROR_H: begin
				src_r = r;
				src_c = w - DW'(1) - c;
			end
			frm_pkg::MODE_MIRROR_V: begin
				src_r = h - DW'(1) - r;
				src_c = c;
			end
			default: begin
				src_r = r;
				src_c = c;
			end
		endcase

		prod = FW'(src_r) * FW'(w);
		sum  = prod + FW'(src_c);
		map.rd_addr = sum[frm_pkg::ADDR_W-1:0];
		map.black   = (mode == frm_pkg::MODE_CROP) && !(r < h && c < w);

		col_end = (c + DW'(1)) >= ow;
		row_end = (r + DW'(1)) >= oh;
		map.last    = col_end && row_end;
		map.nxt_col = col_end ? '0 : frm_pkg::POS_W'(c + DW'(1));
		if (!col_end) begin
			map.nxt_row = frm_pkg::POS_W'(r);
		end else if (row_end) begin
			map.nxt_row = '0;
		end else begin
			map.nxt_row = frm_pkg::POS_W'(r + DW'(1));
		end

		frame = FW'(w) * FW'(h);
		map.wr_wrap = (FW'(write_idx) + FW'(1)) >= frame;
	end

endmodule

// ===== rtl/core/frame_rotate_mirror_crop_unit.sv =====
// Top level of the frame rotate/mirror/crop unit.
//
//  channel | signals                          | direction | request moves
//  --------+----------------------------------+-----------+---------------------------
//  in      | in_valid, in_ready, in_data      | into unit | pixel write or pixel read
//  out     | out_valid, out_ready, out_data   | out       | one output pixel + last
//  cfg     | cfg_valid, cfg_ready, cfg_index, | into unit | one register write
//          | cfg_data                         |           |
//
// A request is taken every cycle while no output pixel is stalled; a read
// request shows its pixel in the next cycle, straight from the store's read register.
// The registered single read port of the pixel store sets that timing.
// A stalled output pixel holds in_ready low until it is taken; writes and reads
// then resume at one per cycle. Reset loads the register defaults and clears the
// positions; the store itself is not cleared, so there is no clearing pass.
module frame_rotate_mirror_crop_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  frm_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output frm_pkg::out_t                 out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [frm_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [frm_pkg::DIM_W-1:0]     cfg_data
);

	// configuration registers
	logic [2:0]                  mode_q;
	logic [frm_pkg::DIM_W-1:0]   width_q, height_q, crop_w_q, crop_h_q;

	// positions
	logic [frm_pkg::ADDR_W-1:0]  write_idx_q;
	logic [frm_pkg::POS_W-1:0]   row_q, col_q;

	// read stage
	logic                        v_s1, black_s1, last_s1;

	logic                        acc, rd_acc, wr_acc;
	frm_pkg::map_t               map;
	frm_pkg::pix_t               wr_pix, rd_pix;

	// Accept while no output pixel waits, or the waiting one leaves now.
	assign in_ready  = !v_s1 || out_ready;
	assign cfg_ready = 1'b1;
	assign acc       = in_valid && in_ready;
	assign rd_acc    = acc && (in_data.opcode == frm_pkg::OP_READ);
	assign wr_acc    = acc && (in_data.opcode == frm_pkg::OP_WRITE);

	assign wr_pix.red   = in_data.red_in;
	assign wr_pix.green = in_data.green_in;
	assign wr_pix.blue  = in_data.blue_in;

	frm_map u_map (
		.mode       (mode_q),
		.width      (width_q),
		.height     (height_q),
		.crop_w     (crop_w_q),
		.crop_h     (crop_h_q),
		.row        (row_q),
		.col        (col_q),
		.write_idx  (write_idx_q),
		.map        (map)
	);

	// Reads and writes come on separate edges, so a read always sees
	// every earlier write without forwarding.
	frm_store u_store (
		.clk     (clk),
		.wr_en   (wr_acc),
		.wr_addr (write_idx_q),
		.wr_data (wr_pix),
		.rd_en   (rd_acc),
		.rd_addr (map.rd_addr),
		.rd_data (rd_pix)
	);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= frm_pkg::MODE_ROT_CCW;
			width_q  <= frm_pkg::DIM_W'(frm_pkg::MAX_DIM);
			height_q <= frm_pkg::DIM_W'(frm_pkg::MAX_DIM);
			crop_w_q <= frm_pkg::DIM_W'(frm_pkg::MAX_DIM);
			crop_h_q <= frm_pkg::DIM_W'(frm_pkg::MAX_DIM);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				frm_pkg::REG_MODE:   mode_q   <= cfg_data[2:0];
				frm_pkg::REG_WIDTH:  width_q  <= cfg_data;
				frm_pkg::REG_HEIGHT: height_q <= cfg_data;
				frm_pkg::REG_CROP_W: crop_w_q <= cfg_data;
				frm_pkg::REG_CROP_H: crop_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the load position on writes, the output position on reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_idx_q <= '0;
			row_q       <= '0;
			col_q       <= '0;
		end else begin
			if (wr_acc) begin
				write_idx_q <= map.wr_wrap ? '0 : write_idx_q + frm_pkg::ADDR_W'(1);
			end
			if (rd_acc) begin
				row_q <= map.nxt_row;
				col_q <= map.nxt_col;
			end
		end
	end

	// Output stage: hold until taken; a new read replaces it in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			black_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else if (rd_acc) begin
			v_s1     <= 1'b1;
			black_s1 <= map.black;
			last_s1  <= map.last;
		end else if (out_ready) begin
			v_s1 <= 1'b0;
		end
	end

	// Drop the stored value for pad positions.
	assign out_valid          = v_s1;
	assign out_data.red_out   = black_s1 ? 8'd0 : rd_pix.red;
	assign out_data.green_out = black_s1 ? 8'd0 : rd_pix.green;
	assign out_data.blue_out  = black_s1 ? 8'd0 : rd_pix.blue;
	assign out_data.last      = last_s1;

endmodule

// ===== rtl/core/frm_checker.sv =====
// Port-level checker for the frame rotate/mirror/crop unit, with its bind.
module frm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input frm_pkg::in_t                  in_data,
	input logic                          out_valid,
	input logic                          out_ready,
	input frm_pkg::out_t                 out_data
);

	logic rd_req;
	assign rd_req = in_valid && in_ready && (in_data.opcode == frm_pkg::OP_READ);

	a_read_gives_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		rd_req |=> out_valid)
		else $error("read request without output pixel");

	a_no_spurious_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(!rd_req && !(out_valid && !out_ready)) |=> !out_valid)
		else $error("output pixel without read request");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no pending pixel");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled output pixel changed");

endmodule

bind frame_rotate_mirror_crop_unit frm_checker u_frm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
